>>> rtl/asxu_pkg.sv
`default_nettype none

package asxu_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned REG_COUNT  = 16;
   localparam int unsigned REG_INDEX_WIDTH = $clog2(REG_COUNT);
   localparam logic [REG_INDEX_WIDTH-1:0] PC_INDEX = REG_INDEX_WIDTH'(REG_COUNT - 1);
   localparam logic [WORD_WIDTH-1:0] PC_RESET = 32'd4;

   // bits 27:24 of a branch, bits 7:4 of a multiply
   localparam logic [3:0] BRANCH_CODE = 4'hA;
   localparam logic [3:0] MUL_MARK    = 4'h9;

   typedef enum logic [2:0] {
      STATUS_EXECUTED = 3'd0,
      STATUS_SKIPPED  = 3'd1,
      STATUS_TRANSFER = 3'd2,
      STATUS_INVALID  = 3'd3,
      STATUS_HALT     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      COND_EQ = 4'h0,
      COND_NE = 4'h1,
      COND_GE = 4'hA,
      COND_LT = 4'hB,
      COND_GT = 4'hC,
      COND_LE = 4'hD,
      COND_AL = 4'hE
   } cond_type;

   typedef enum logic [3:0] {
      OP_AND = 4'h0,
      OP_EOR = 4'h1,
      OP_SUB = 4'h2,
      OP_RSB = 4'h3,
      OP_ADD = 4'h4,
      OP_TST = 4'h8,
      OP_TEQ = 4'h9,
      OP_CMP = 4'hA,
      OP_ORR = 4'hC,
      OP_MOV = 4'hD
   } opcode_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   typedef struct packed {
      status_type                 status;
      logic                       wr_en;
      logic [REG_INDEX_WIDTH-1:0] wr_idx;
      logic [WORD_WIDTH-1:0]      wr_val;
      logic [3:0]                 flags;
      logic [WORD_WIDTH-1:0]      pc_next;
   } exec_result_type;

endpackage

`default_nettype wire

>>> rtl/asxu_ram.sv
`default_nettype none

module asxu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read returns the old contents on a same-edge write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

>>> rtl/asxu_exec.sv
`default_nettype none

module asxu_exec (
   input  wire logic [31:0]               word,
   input  wire logic [31:0]               rn_dp_val,
   input  wire logic [31:0]               rm_val,
   input  wire logic [31:0]               rs_val,
   input  wire logic [31:0]               rn_mul_val,
   input  wire logic [31:0]               pc_plus4,
   input  wire logic [3:0]                flags,
   output asxu_pkg::exec_result_type      result
);

   logic        flag_n;
   logic        flag_z;
   logic        flag_c;
   logic        flag_v;
   logic        cond_ok;

   logic [4:0]  rot_amt;
   logic [63:0] imm_rot;
   logic [7:0]  shift_amt;
   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;
   logic [63:0] ror_wide;
   logic [31:0] sh_res;
   logic        sh_carry;
   logic [31:0] op2;
   logic        op2_carry;
   logic        op2_ok;

   logic [32:0] add_sum;
   logic [32:0] sub_diff;
   logic [32:0] rsb_diff;
   logic [31:0] alu_res;
   logic        alu_carry;
   logic        alu_ok;
   logic        alu_writes;

   logic [31:0] mul_prod;
   logic [31:0] mul_res;
   logic        mul_ok;
   logic [31:0] branch_off;

   function automatic asxu_pkg::shift_type shift_type_of(input logic [1:0] code);
      return asxu_pkg::shift_type'(code);
   endfunction

   assign {flag_n, flag_z, flag_c, flag_v} = flags;

   always_comb begin
      case (word[31:28])
         asxu_pkg::COND_EQ: cond_ok = flag_z;
         asxu_pkg::COND_NE: cond_ok = !flag_z;
         asxu_pkg::COND_GE: cond_ok = (flag_n == flag_v);
         asxu_pkg::COND_LT: cond_ok = (flag_n != flag_v);
         asxu_pkg::COND_GT: cond_ok = !flag_z && (flag_n == flag_v);
         asxu_pkg::COND_LE: cond_ok = flag_z || (flag_n != flag_v);
         asxu_pkg::COND_AL: cond_ok = 1'b1;
         default:           cond_ok = 1'b0;
      endcase
   end

   // operand 2: rotated immediate or shifted register
   always_comb begin
      rot_amt   = {word[11:8], 1'b0};
      imm_rot   = {24'd0, word[7:0], 24'd0, word[7:0]} >> rot_amt;
      shift_amt = word[4] ? rs_val[7:0] : {3'd0, word[11:7]};
      lsl_wide  = {1'b0, rm_val} << shift_amt;
      lsr_wide  = {rm_val, 1'b0} >> shift_amt;
      asr_wide  = 33'($signed({rm_val, 1'b0}) >>> shift_amt);
      ror_wide  = {rm_val, rm_val} >> shift_amt[4:0];

      case (shift_type_of(word[6:5]))
         asxu_pkg::SHIFT_LSL: begin
            sh_res   = lsl_wide[31:0];
            sh_carry = lsl_wide[32];
         end
         asxu_pkg::SHIFT_LSR: begin
            sh_res   = lsr_wide[32:1];
            sh_carry = lsr_wide[0];
         end
         asxu_pkg::SHIFT_ASR: begin
            sh_res   = asr_wide[32:1];
            sh_carry = asr_wide[0];
         end
         default: begin
            sh_res   = ror_wide[31:0];
            sh_carry = ror_wide[31];
         end
      endcase
      if (shift_amt == 8'd0) begin
         sh_res   = rm_val;
         sh_carry = 1'b0;
      end

      if (word[25]) begin
         op2       = imm_rot[31:0];
         op2_carry = (rot_amt != 5'd0) && imm_rot[31];
         op2_ok    = 1'b1;
      end else begin
         op2       = sh_res;
         op2_carry = sh_carry;
         op2_ok    = (word[3:0] != asxu_pkg::PC_INDEX) && !(word[4] && word[7]);
      end
   end

   always_comb begin
      add_sum    = {1'b0, rn_dp_val} + {1'b0, op2};
      sub_diff   = {1'b0, rn_dp_val} - {1'b0, op2};
      rsb_diff   = {1'b0, op2} - {1'b0, rn_dp_val};
      alu_res    = '0;
      alu_carry  = 1'b0;
      alu_ok     = 1'b1;
      alu_writes = 1'b1;
      unique case (word[24:21]) inside
         asxu_pkg::OP_AND, asxu_pkg::OP_TST: begin
            alu_res   = rn_dp_val & op2;
            alu_carry = op2_carry;
         end
         asxu_pkg::OP_EOR, asxu_pkg::OP_TEQ: begin
            alu_res   = rn_dp_val ^ op2;
            alu_carry = op2_carry;
         end
         asxu_pkg::OP_SUB, asxu_pkg::OP_CMP: begin
            alu_res   = sub_diff[31:0];
            alu_carry = !sub_diff[32];
         end
         asxu_pkg::OP_RSB: begin
            alu_res   = rsb_diff[31:0];
            alu_carry = !rsb_diff[32];
         end
         asxu_pkg::OP_ADD: begin
            alu_res   = add_sum[31:0];
            alu_carry = add_sum[32];
         end
         asxu_pkg::OP_ORR: begin
            alu_res   = rn_dp_val | op2;
            alu_carry = op2_carry;
         end
         asxu_pkg::OP_MOV: begin
            alu_res   = op2;
            alu_carry = op2_carry;
         end
         default: begin
            alu_ok = 1'b0;
         end
      endcase
      if (word[24:21] == asxu_pkg::OP_TST || word[24:21] == asxu_pkg::OP_TEQ ||
          word[24:21] == asxu_pkg::OP_CMP) begin
         alu_writes = 1'b0;
      end
   end

   assign mul_prod = rm_val * rs_val;
   assign mul_res  = word[21] ? mul_prod + rn_mul_val : mul_prod;
   assign mul_ok   = (word[19:16] != word[3:0]) &&
                     (word[19:16] != asxu_pkg::PC_INDEX) &&
                     (word[3:0]   != asxu_pkg::PC_INDEX) &&
                     (word[11:8]  != asxu_pkg::PC_INDEX) &&
                     (word[15:12] != asxu_pkg::PC_INDEX);

   assign branch_off = {{6{word[23]}}, word[23:0], 2'b00};

   always_comb begin
      result.status  = asxu_pkg::STATUS_EXECUTED;
      result.wr_en   = 1'b0;
      result.wr_idx  = '0;
      result.wr_val  = '0;
      result.flags   = flags;
      result.pc_next = pc_plus4;

      if (word == 32'd0) begin
         result.status = asxu_pkg::STATUS_HALT;
      end else if (!cond_ok) begin
         result.status = asxu_pkg::STATUS_SKIPPED;
      end else if (word[27:24] == asxu_pkg::BRANCH_CODE) begin
         result.pc_next = pc_plus4 + branch_off + 32'd4;
      end else if (word[27:26] != 2'd0 && word[22:21] == 2'd0) begin
         result.status = asxu_pkg::STATUS_TRANSFER;
      end else if (word[27:22] == 6'd0 && word[7:4] == asxu_pkg::MUL_MARK) begin
         if (!mul_ok) begin
            result.status = asxu_pkg::STATUS_INVALID;
         end else begin
            result.wr_en  = 1'b1;
            result.wr_idx = word[19:16];
            result.wr_val = mul_res;
            if (word[20]) begin
               result.flags = {mul_res[31], mul_res == 32'd0, flag_c, flag_v};
            end
         end
      end else if (word[27:26] == 2'd0) begin
         if (!(op2_ok && alu_ok)) begin
            result.status = asxu_pkg::STATUS_INVALID;
         end else begin
            if (alu_writes) begin
               result.wr_en  = 1'b1;
               result.wr_idx = word[15:12];
               result.wr_val = alu_res;
               if (word[15:12] == asxu_pkg::PC_INDEX) begin
                  result.pc_next = alu_res;
               end
            end
            if (word[20]) begin
               result.flags = {alu_res[31], alu_res == 32'd0, alu_carry, flag_v};
            end
         end
      end else begin
         result.status = asxu_pkg::STATUS_INVALID;
      end
   end

endmodule

`default_nettype wire

>>> rtl/arm_subset_execute_unit.sv
`default_nettype none
// Execute unit for a subset of the 32-bit ARM instruction set.
// The req_ channel carries one fetched instruction word per item; the rsp_
// channel returns one result item per instruction: status, the general
// register write, the flags and the new program counter.
// Items are accepted when req_valid is high and req_stall is low, and
// results are taken when rsp_valid is high and rsp_stall is low.
// The word is registered together with the register file read (two
// dual-read RAM copies of r0-r14), then decode, shifter, ALU or multiplier
// and the state update run combinationally into the result register. The
// write of one instruction is forwarded to the next.
// Throughput is one item per cycle while the receiver keeps up.
// When rsp_stall holds a result, the registered word waits and req_stall
// rises; nothing is lost or executed twice.
// Reset (synchronous, active high) clears r0-r14 through per-entry valid
// bits, sets r15 to 4 and the flags to zero, and empties both stages.
module arm_subset_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_dest_written,
   output logic [3:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic [3:0]       rsp_flags_nzcv,
   output logic [31:0]      rsp_pc_after
);

   localparam int unsigned IW = asxu_pkg::REG_INDEX_WIDTH;
   localparam int unsigned DW = asxu_pkg::WORD_WIDTH;

   logic                        in_valid_ff;
   logic [DW-1:0]               in_word_ff;
   logic                        fire;
   logic                        accept;

   logic [DW-1:0]               pc_ff;
   logic [DW-1:0]               pc_plus4;
   logic [3:0]                  flags_ff;
   logic [asxu_pkg::REG_COUNT-1:0] ent_valid_ff;

   logic                        fwd_valid_ff;
   logic [IW-1:0]               fwd_idx_ff;
   logic [DW-1:0]               fwd_val_ff;

   logic                        ram_we;
   logic [DW-1:0]               ram_rm;
   logic [DW-1:0]               ram_rs;
   logic [DW-1:0]               ram_rn_dp;
   logic [DW-1:0]               ram_rn_mul;

   logic [DW-1:0]               rm_val;
   logic [DW-1:0]               rs_val;
   logic [DW-1:0]               rn_dp_val;
   logic [DW-1:0]               rn_mul_val;

   asxu_pkg::exec_result_type   exec_res;

   logic                        rsp_valid_ff;
   logic [2:0]                  rsp_status_ff;
   logic                        rsp_written_ff;
   logic [3:0]                  rsp_index_ff;
   logic [DW-1:0]               rsp_value_ff;
   logic [3:0]                  rsp_flags_ff;
   logic [DW-1:0]               rsp_pc_ff;

   // r15 reads the advanced PC; a write landing with the read is forwarded
   function automatic logic [DW-1:0] operand(
      input logic [IW-1:0] idx,
      input logic [DW-1:0] ram_data,
      input logic [DW-1:0] pc_val,
      input logic          fwd_hit,
      input logic [DW-1:0] fwd_val,
      input logic          ent_ok
   );
      logic [DW-1:0] val;
      if (idx == asxu_pkg::PC_INDEX) begin
         val = pc_val;
      end else if (fwd_hit) begin
         val = fwd_val;
      end else if (ent_ok) begin
         val = ram_data;
      end else begin
         val = '0;
      end
      return val;
   endfunction

   function automatic logic [IW-1:0] in_word_rn_dp(input logic [DW-1:0] word);
      return word[19:16];
   endfunction

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign pc_plus4  = pc_ff + DW'(4);
   assign ram_we    = fire && exec_res.wr_en && (exec_res.wr_idx != asxu_pkg::PC_INDEX);

   asxu_ram #(
      .WIDTH (asxu_pkg::WORD_WIDTH),
      .DEPTH (asxu_pkg::REG_COUNT)
   ) u_ram_rm_rs (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (exec_res.wr_idx),
      .wr_data   (exec_res.wr_val),
      .rd_en     (accept),
      .rd_addr_a (req_instruction_word[3:0]),
      .rd_addr_b (req_instruction_word[11:8]),
      .rd_data_a (ram_rm),
      .rd_data_b (ram_rs)
   );

   asxu_ram #(
      .WIDTH (asxu_pkg::WORD_WIDTH),
      .DEPTH (asxu_pkg::REG_COUNT)
   ) u_ram_rn (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (exec_res.wr_idx),
      .wr_data   (exec_res.wr_val),
      .rd_en     (accept),
      .rd_addr_a (in_word_rn_dp(req_instruction_word)),
      .rd_addr_b (req_instruction_word[15:12]),
      .rd_data_a (ram_rn_dp),
      .rd_data_b (ram_rn_mul)
   );

   always_comb begin
      rm_val = operand(in_word_ff[3:0], ram_rm, pc_plus4,
                       fwd_valid_ff && (fwd_idx_ff == in_word_ff[3:0]),
                       fwd_val_ff, ent_valid_ff[in_word_ff[3:0]]);
      rs_val = operand(in_word_ff[11:8], ram_rs, pc_plus4,
                       fwd_valid_ff && (fwd_idx_ff == in_word_ff[11:8]),
                       fwd_val_ff, ent_valid_ff[in_word_ff[11:8]]);
      rn_dp_val = operand(in_word_ff[19:16], ram_rn_dp, pc_plus4,
                          fwd_valid_ff && (fwd_idx_ff == in_word_ff[19:16]),
                          fwd_val_ff, ent_valid_ff[in_word_ff[19:16]]);
      rn_mul_val = operand(in_word_ff[15:12], ram_rn_mul, pc_plus4,
                           fwd_valid_ff && (fwd_idx_ff == in_word_ff[15:12]),
                           fwd_val_ff, ent_valid_ff[in_word_ff[15:12]]);
   end

   asxu_exec u_exec (
      .word       (in_word_ff),
      .rn_dp_val  (rn_dp_val),
      .rm_val     (rm_val),
      .rs_val     (rs_val),
      .rn_mul_val (rn_mul_val),
      .pc_plus4   (pc_plus4),
      .flags      (flags_ff),
      .result     (exec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= asxu_pkg::PC_RESET;
         flags_ff     <= '0;
         ent_valid_ff <= '0;
      end else begin
         if (accept) begin
            in_valid_ff  <= 1'b1;
            in_word_ff   <= req_instruction_word;
            fwd_valid_ff <= ram_we;
            fwd_idx_ff   <= exec_res.wr_idx;
            fwd_val_ff   <= exec_res.wr_val;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end

         if (fire) begin
            rsp_valid_ff   <= 1'b1;
            rsp_status_ff  <= exec_res.status;
            rsp_written_ff <= exec_res.wr_en;
            rsp_index_ff   <= exec_res.wr_idx;
            rsp_value_ff   <= exec_res.wr_val;
            rsp_flags_ff   <= exec_res.flags;
            rsp_pc_ff      <= exec_res.pc_next;
            pc_ff          <= exec_res.pc_next;
            flags_ff       <= exec_res.flags;
            if (ram_we) begin
               ent_valid_ff[exec_res.wr_idx] <= 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_dest_written = rsp_written_ff;
   assign rsp_dest_index   = rsp_index_ff;
   assign rsp_dest_value   = rsp_value_ff;
   assign rsp_flags_nzcv   = rsp_flags_ff;
   assign rsp_pc_after     = rsp_pc_ff;

endmodule

`default_nettype wire

>>> tb/sv/arm_subset_execute_unit_tb.sv
`timescale 1ns / 100ps

module arm_subset_execute_unit_tb;
   import asxu_pkg::*;

   localparam logic [3:0] COND_NEVER  = 4'hF;
   localparam logic [3:0] OP_UNLISTED = 4'h5;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instruction_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_dest_written;
   logic [3:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value;
   logic [3:0]  rsp_flags_nzcv;
   logic [31:0] rsp_pc_after;

   // architectural state as the testbench sees it
   logic [31:0] gpr_model [REG_COUNT];
   logic [3:0]  nzcv_model;

   exec_result_type retire_queue [$];
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned status_tally [5] = '{0, 0, 0, 0, 0};
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit allow_idle = 1'b1;

   arm_subset_execute_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_dest_written     (rsp_dest_written),
      .rsp_dest_index       (rsp_dest_index),
      .rsp_dest_value       (rsp_dest_value),
      .rsp_flags_nzcv       (rsp_flags_nzcv),
      .rsp_pc_after         (rsp_pc_after)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- encoders

   function automatic logic [31:0] dp_word(logic [3:0] cond, logic imm, logic [3:0] opc,
                                           logic s, logic [3:0] rn, logic [3:0] rd,
                                           logic [11:0] operand);
      return {cond, 2'b00, imm, opc, s, rn, rd, operand};
   endfunction

   function automatic logic [11:0] shift_imm(logic [4:0] amount, shift_type kind,
                                             logic [3:0] rm);
      return {amount, kind, 1'b0, rm};
   endfunction

   function automatic logic [11:0] shift_reg(logic [3:0] rs, shift_type kind, logic [3:0] rm);
      return {rs, 1'b0, kind, 1'b1, rm};
   endfunction

   function automatic logic [31:0] mul_word(logic [3:0] cond, logic acc, logic s,
                                            logic [3:0] rd, logic [3:0] rn,
                                            logic [3:0] rs, logic [3:0] rm);
      return {cond, 6'b000000, acc, s, rd, rn, rs, MUL_MARK, rm};
   endfunction

   // --------------------------------------------------------------- predictor

   function automatic logic cond_passes(logic [3:0] code, logic [3:0] f);
      logic n, z, v;
      n = f[3];
      z = f[2];
      v = f[0];
      case (code)
         COND_EQ: return z;
         COND_NE: return !z;
         COND_GE: return n == v;
         COND_LT: return n != v;
         COND_GT: return !z && (n == v);
         COND_LE: return z || (n != v);
         COND_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // register-form operand 2; returns 0 for an encoding the block rejects
   function automatic logic shift_operand(input logic [31:0] w, output logic [31:0] value,
                                          output logic carry);
      logic [31:0] v;
      int unsigned amt, r;
      value = '0;
      carry = 1'b0;
      if (w[3:0] == PC_INDEX) return 1'b0;
      if (w[4]) begin
         if (w[7]) return 1'b0;
         amt = gpr_model[w[11:8]][7:0];
      end else begin
         amt = w[11:7];
      end
      v = gpr_model[w[3:0]];
      if (amt == 0) begin
         value = v;
         return 1'b1;
      end
      case (shift_type'(w[6:5]))
         SHIFT_LSL: begin
            if (amt < 32) begin
               value = v << amt;
               carry = v[32 - amt];
            end else begin
               carry = (amt == 32) ? v[0] : 1'b0;
            end
         end
         SHIFT_LSR: begin
            if (amt < 32) begin
               value = v >> amt;
               carry = v[amt - 1];
            end else begin
               carry = (amt == 32) ? v[31] : 1'b0;
            end
         end
         SHIFT_ASR: begin
            if (amt < 32) begin
               value = $signed(v) >>> amt;
               carry = v[amt - 1];
            end else begin
               value = {32{v[31]}};
               carry = v[31];
            end
         end
         default: begin
            r = amt % 32;
            if (r == 0) begin
               value = v;
               carry = v[31];
            end else begin
               value = (v >> r) | (v << (32 - r));
               carry = v[r - 1];
            end
         end
      endcase
      return 1'b1;
   endfunction

   function automatic exec_result_type retire_instruction(logic [31:0] w);
      exec_result_type r;
      logic [31:0] op2, rn_val, res, prod, offset;
      logic [3:0] opc, rd;
      logic sc, carry, ok;
      int unsigned rot;
      r = '0;
      r.status = STATUS_EXECUTED;
      gpr_model[PC_INDEX] += 32'd4;
      if (w == '0) begin
         r.status = STATUS_HALT;
      end else if (!cond_passes(w[31:28], nzcv_model)) begin
         r.status = STATUS_SKIPPED;
      end else if (w[27:24] == BRANCH_CODE) begin
         offset = {{8{w[23]}}, w[23:0]};
         gpr_model[PC_INDEX] += (offset + 32'd1) << 2;
      end else if (w[27:26] != 2'b00 && w[22:21] == 2'b00) begin
         r.status = STATUS_TRANSFER;
      end else if (w[27:22] == '0 && w[7:4] == MUL_MARK) begin
         if (w[19:16] == w[3:0] || w[19:16] == PC_INDEX || w[3:0] == PC_INDEX ||
             w[11:8] == PC_INDEX || w[15:12] == PC_INDEX) begin
            r.status = STATUS_INVALID;
         end else begin
            prod = gpr_model[w[3:0]] * gpr_model[w[11:8]];
            if (w[21]) prod += gpr_model[w[15:12]];
            gpr_model[w[19:16]] = prod;
            r.wr_en = 1'b1;
            r.wr_idx = w[19:16];
            r.wr_val = prod;
            if (w[20]) nzcv_model = {prod[31], prod == '0, nzcv_model[1:0]};
         end
      end else if (w[27:26] == 2'b00) begin
         opc = w[24:21];
         rd = w[15:12];
         rn_val = gpr_model[w[19:16]];
         ok = 1'b1;
         res = '0;
         carry = 1'b0;
         sc = 1'b0;
         op2 = '0;
         if (w[25]) begin
            rot = 2 * w[11:8];
            op2 = {24'd0, w[7:0]};
            if (rot != 0) begin
               op2 = (op2 >> rot) | (op2 << (32 - rot));
               sc = op2[31];
            end
         end else begin
            ok = shift_operand(w, op2, sc);
         end
         if (ok) begin
            case (opc)
               OP_AND, OP_TST: begin res = rn_val & op2; carry = sc; end
               OP_EOR, OP_TEQ: begin res = rn_val ^ op2; carry = sc; end
               OP_SUB, OP_CMP: begin res = rn_val - op2; carry = op2 <= rn_val; end
               OP_RSB:         begin res = op2 - rn_val; carry = rn_val <= op2; end
               OP_ADD:         begin res = rn_val + op2; carry = res < rn_val; end
               OP_ORR:         begin res = rn_val | op2; carry = sc; end
               OP_MOV:         begin res = op2; carry = sc; end
               default:        ok = 1'b0;
            endcase
         end
         if (!ok) begin
            r.status = STATUS_INVALID;
         end else begin
            if (opc != OP_TST && opc != OP_TEQ && opc != OP_CMP) begin
               gpr_model[rd] = res;
               r.wr_en = 1'b1;
               r.wr_idx = rd;
               r.wr_val = res;
            end
            if (w[20]) nzcv_model = {res[31], res == '0, carry, nzcv_model[0]};
         end
      end else begin
         r.status = STATUS_INVALID;
      end
      r.flags = nzcv_model;
      r.pc_next = gpr_model[PC_INDEX];
      return r;
   endfunction

   // ----------------------------------------------------------- drive, check

   task automatic send_instruction(logic [31:0] word);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instruction_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      retire_queue.push_back(retire_instruction(word));
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!allow_idle) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(string field, logic [31:0] expected,
                                       logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      exec_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (retire_queue.size() == 0) begin
            $error("result item with no instruction outstanding");
            error_count++;
         end else begin
            want = retire_queue.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("dest_written", 32'(want.wr_en), 32'(rsp_dest_written));
            check_field("dest_index", 32'(want.wr_idx), 32'(rsp_dest_index));
            check_field("dest_value", want.wr_val, rsp_dest_value);
            check_field("flags_nzcv", 32'(want.flags), 32'(rsp_flags_nzcv));
            check_field("pc_after", want.pc_next, rsp_pc_after);
            status_tally[int'(want.status)]++;
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("arm_subset_execute_unit_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------ tests

   task automatic test_alu_operations();
      send_instruction(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd0, 12'h0FF));
      // 2 rotated right by 2: top bit set, shifter carry set
      send_instruction(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h102));
      send_instruction(dp_word(COND_AL, 1'b1, OP_SUB, 1'b1, 4'd3, 4'd2, 12'h001));
      send_instruction(dp_word(COND_AL, 1'b1, OP_ADD, 1'b1, 4'd2, 4'd3, 12'h001));
      send_instruction(dp_word(COND_AL, 1'b1, OP_RSB, 1'b1, 4'd0, 4'd4, 12'h000));
      // pc as first operand
      send_instruction(dp_word(COND_AL, 1'b0, OP_ORR, 1'b0, PC_INDEX, 4'd7,
                               shift_imm(5'd0, SHIFT_LSL, 4'd0)));
      send_instruction(dp_word(COND_AL, 1'b0, OP_TST, 1'b1, 4'd1, 4'd0,
                               shift_imm(5'd0, SHIFT_LSL, 4'd2)));
      send_instruction(dp_word(COND_AL, 1'b0, OP_TEQ, 1'b1, 4'd0, 4'd0,
                               shift_imm(5'd0, SHIFT_LSL, 4'd0)));
      send_instruction(dp_word(COND_AL, 1'b1, OP_CMP, 1'b1, 4'd0, 4'd0, 12'h0FF));
   endtask

   task automatic test_conditions();
      send_instruction('0);
      send_instruction(dp_word(COND_EQ, 1'b0, OP_AND, 1'b1, 4'd2, 4'd5,
                               shift_imm(5'd0, SHIFT_LSL, 4'd0)));
      send_instruction(dp_word(COND_LT, 1'b0, OP_EOR, 1'b1, 4'd2, 4'd6,
                               shift_imm(5'd0, SHIFT_LSL, 4'd1)));
      send_instruction(dp_word(COND_LE, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd11, 12'h001));
      send_instruction(dp_word(COND_NEVER, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd11, 12'h002));
   endtask

   task automatic test_shifter();
      send_instruction(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd8, 12'h020));
      send_instruction(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9,
                               shift_reg(4'd8, SHIFT_LSL, 4'd0)));
      send_instruction(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9,
                               shift_reg(4'd8, SHIFT_ROR, 4'd2)));
      // amount 255 from the low byte of an all-ones register
      send_instruction(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9,
                               shift_reg(4'd2, SHIFT_ASR, 4'd1)));
      // low byte zero: pass through with carry clear
      send_instruction(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9,
                               shift_reg(4'd1, SHIFT_LSR, 4'd0)));
   endtask

   task automatic test_multiply();
      send_instruction(mul_word(COND_AL, 1'b1, 1'b1, 4'd10, 4'd2, 4'd0, 4'd0));
      // destination equal to Rm is rejected
      send_instruction(mul_word(COND_AL, 1'b0, 1'b0, 4'd0, 4'd0, 4'd1, 4'd0));
   endtask

   task automatic test_branch_and_pc();
      send_instruction(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, PC_INDEX, 12'hF01));
      send_instruction({COND_AL, BRANCH_CODE, 24'h800000});
   endtask

   task automatic test_rejected_words();
      send_instruction({COND_AL, 2'b01, 2'b01, 2'b10, 22'h001000});
      send_instruction({COND_AL, 2'b11, 2'b00, 2'b01, 22'h000000});
      send_instruction(dp_word(COND_AL, 1'b1, OP_UNLISTED, 1'b1, 4'd0, 4'd1, 12'h001));
      send_instruction(dp_word(COND_AL, 1'b0, OP_MOV, 1'b0, 4'd0, 4'd1,
                               shift_imm(5'd3, SHIFT_LSL, PC_INDEX)));
      send_instruction(dp_word(COND_AL, 1'b0, OP_MOV, 1'b0, 4'd0, 4'd1,
                               {4'd1, 1'b1, SHIFT_LSR, 1'b1, 4'd2}));
   endtask

   function automatic logic [3:0] pick_reg();
      return ($urandom_range(0, 19) == 0) ? PC_INDEX : 4'($urandom_range(0, 14));
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [3:0] cond, opc;
      logic [11:0] operand;
      logic imm;
      logic [23:0] offset;
      int unsigned pick;
      cond = ($urandom_range(0, 3) == 0) ? 4'($urandom) : COND_AL;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 10))
            0: opc = OP_AND;
            1: opc = OP_EOR;
            2: opc = OP_SUB;
            3: opc = OP_RSB;
            4: opc = OP_ADD;
            5: opc = OP_TST;
            6: opc = OP_TEQ;
            7: opc = OP_CMP;
            8: opc = OP_ORR;
            9: opc = OP_MOV;
            default: opc = 4'($urandom);
         endcase
         imm = 1'b0;
         case ($urandom_range(0, 2))
            0: begin
               imm = 1'b1;
               // small values often, so later register shifts land near 32
               operand = {($urandom_range(0, 1) ? 4'($urandom) : 4'd0), 8'($urandom)};
            end
            1: operand = shift_imm(5'($urandom), shift_type'(2'($urandom)), pick_reg());
            default: operand = shift_reg(pick_reg(), shift_type'(2'($urandom)), pick_reg());
         endcase
         return dp_word(cond, imm, opc, 1'($urandom), pick_reg(), pick_reg(), operand);
      end else if (pick < 70) begin
         return mul_word(cond, 1'($urandom), 1'($urandom), pick_reg(), pick_reg(),
                         pick_reg(), pick_reg());
      end else if (pick < 80) begin
         offset = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                               : {{16{1'($urandom)}}, 8'($urandom)};
         return {cond, BRANCH_CODE, offset};
      end else if (pick < 87) begin
         return {cond, 2'($urandom_range(1, 3)), 26'($urandom)};
      end else if (pick < 90) begin
         return '0;
      end
      return $urandom;
   endfunction

   task automatic test_random_program(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         // leave stretches with no idling on either side
         allow_idle = (i % 200) < 150;
         send_instruction(random_instruction());
      end
   endtask

   task automatic test_unthrottled_tail(int unsigned count);
      allow_idle = 1'b0;
      for (int unsigned i = 0; i < count; i++) send_instruction(random_instruction());
   endtask

   initial begin
      for (int i = 0; i < REG_COUNT; i++) gpr_model[i] = '0;
      gpr_model[PC_INDEX] = PC_RESET;
      nzcv_model = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_alu_operations();
      test_conditions();
      test_shifter();
      test_multiply();
      test_branch_and_pc();
      test_rejected_words();
      test_random_program(520);
      test_unthrottled_tail(130);

      req_valid <= 1'b0;
      while (retire_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d instruction words (directed then random), checked %0d results",
               items_sent, results_checked);
      $display("by status: executed %0d, skipped %0d, transfer %0d, invalid %0d, halt %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (error_count == 0 && retire_queue.size() == 0) begin
         $display("arm_subset_execute_unit_tb passed");
      end else begin
         $display("arm_subset_execute_unit_tb failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/asxu_pkg.sv
rtl/asxu_ram.sv
rtl/asxu_exec.sv
rtl/arm_subset_execute_unit.sv
tb/sv/arm_subset_execute_unit_tb.sv
